// ----- hw/rtl/csrt_pkg.sv -----
// Package for the coin session relay timer: item types, request codes,
// configuration register indexes, widths and reset values. No dependencies.

package csrt_pkg;

    // Relay test request codes carried in each item.
    localparam logic [1:0] REQ_NONE   = 2'd0;
    localparam logic [1:0] REQ_START  = 2'd1;
    localparam logic [1:0] REQ_CANCEL = 2'd2;

    // Configuration register indexes.
    localparam int CFG_INDEX_WIDTH = 3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RELAY_ACTIVE_LOW  = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_P1_COIN_HIGH      = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_P2_COIN_HIGH      = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INACTIVITY_TIMEOUT = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TEST_PULSE        = 3'd4;

    // Configuration widths and reset values.
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int PULSE_WIDTH     = 31;
    localparam logic [31:0] TIMEOUT_RESET = 32'd180000;
    localparam logic [PULSE_WIDTH-1:0] PULSE_RESET = 31'd1000;

    // One input item: a tick with time, pin levels and test requests.
    typedef struct packed {
        logic [31:0] now_ms;
        logic        p1_coin_raw;
        logic        p2_coin_raw;
        logic        p1_trigger_raw;
        logic        p2_trigger_raw;
        logic [1:0]  p1_test_req;
        logic [1:0]  p2_test_req;
    } t_tick_in;

    // One result item: relay and session status after the tick.
    typedef struct packed {
        logic p1_relay_level;
        logic p2_relay_level;
        logic p1_relay_energized;
        logic p2_relay_energized;
        logic p1_session_active;
        logic p2_session_active;
    } t_tick_out;

endpackage

// ----- hw/rtl/coin_session_relay_timer_unit.sv -----
// Top level of the coin session relay timer: per-player session, test window
// and relay control. Depends on csrt_pkg.
//
//  Channel   Direction  Handshake                  Payload
//  in        input      i_in_valid / o_in_stall    i_in_item  (t_tick_in)
//  out       output     o_out_valid / i_out_stall  o_out_item (t_tick_out)
//  cfg       input      i_cfg_we                   i_cfg_index, i_cfg_wdata
//
// An item passes through the input register and then the result register.
// One item is accepted every cycle while the output side takes results;
// the single combinational pass for both players between the two registers
// sets that figure. A stall on the output holds the result and then backs
// up into the input register. Synchronous active-low reset clears sessions,
// windows and valid flags and restores the register defaults.

module coin_session_relay_timer_unit
    import csrt_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  t_tick_in                   i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output t_tick_out                  o_out_item,
    input  logic                       i_cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  i_cfg_wdata
);

    localparam int W  = TIME_WIDTH;
    localparam int CW = (W > 32) ? W : 32;
    localparam logic [W-1:0] HALF_M1 = {1'b0, {(W-1){1'b1}}};

    // Configuration registers.
    logic                   r_relay_active_low;
    logic [1:0]             r_coin_high;
    logic [31:0]            r_timeout;
    logic [PULSE_WIDTH-1:0] r_pulse;

    // Pipeline registers.
    logic      r_in_vld;
    t_tick_in  r_in;
    logic      r_out_vld;
    t_tick_out r_out;

    // Per-player state.
    logic         r_active [2];
    logic [W-1:0] r_last   [2];
    logic [W-1:0] r_until  [2];
    logic         r_tvalid [2];

    // Next values from the single pass.
    logic         n_active [2];
    logic [W-1:0] n_last   [2];
    logic [W-1:0] n_until  [2];
    logic         n_tvalid [2];
    logic         n_relay  [2];

    logic         w_accept;
    logic         w_adv;
    logic [W-1:0] w_now;
    logic [W-1:0] w_pulse_sat;
    logic         w_coin_raw [2];
    logic         w_trig_raw [2];
    logic [1:0]   w_req      [2];

    // Handshake: the input register moves on when the result register is free.
    assign w_adv      = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !w_adv;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    // Time of the tick, taken modulo the time range.
    assign w_now = W'(r_in.now_ms);

    // Test pulse length, saturated below half the time range.
    generate
        if (W > PULSE_WIDTH) begin : g_pulse_wide
            assign w_pulse_sat = W'(r_pulse);
        end else begin : g_pulse_narrow
            assign w_pulse_sat = (r_pulse > PULSE_WIDTH'(HALF_M1)) ? HALF_M1 : W'(r_pulse);
        end
    endgenerate

    // Per-player pin fields in player order.
    assign w_coin_raw[0] = r_in.p1_coin_raw;
    assign w_coin_raw[1] = r_in.p2_coin_raw;
    assign w_trig_raw[0] = r_in.p1_trigger_raw;
    assign w_trig_raw[1] = r_in.p2_trigger_raw;
    assign w_req[0]      = r_in.p1_test_req;
    assign w_req[1]      = r_in.p2_test_req;

    // Session, test window and relay logic of one player.
    genvar g;
    generate
        for (g = 0; g < 2; g++) begin : g_player
            logic         w_coin;
            logic         w_trig;
            logic         w_valid_a;
            logic         w_active_a;
            logic [W-1:0] w_last_a;
            logic [W-1:0] w_last_b;
            logic [W-1:0] w_dist;
            logic         w_pending;
            logic [W-1:0] w_idle;
            logic         w_timed_out;
            logic [W-1:0] n_until_p;
            logic         n_tvalid_p;
            logic         n_active_p;
            logic [W-1:0] n_last_p;
            logic         n_relay_p;

            assign w_coin = r_coin_high[g] ? w_coin_raw[g] : !w_coin_raw[g];
            assign w_trig = !w_trig_raw[g];

            // A request is applied before the relay logic of the same tick.
            always_comb begin
                n_until_p = r_until[g];
                w_valid_a = r_tvalid[g];
                case (w_req[g])
                    REQ_START: begin
                        n_until_p = w_now + w_pulse_sat;
                        w_valid_a = 1'b1;
                    end
                    REQ_CANCEL: begin
                        w_valid_a = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end

            // A coin opens the session and marks activity.
            assign w_active_a = r_active[g] || w_coin;
            assign w_last_a   = w_coin ? w_now : r_last[g];

            // The window is pending while its end lies ahead by under half a range.
            assign w_dist    = n_until_p - w_now;
            assign w_pending = w_valid_a && (w_dist != '0) && !w_dist[W-1];

            // A pressed trigger refreshes activity; idle time checks the timeout.
            assign w_last_b    = w_trig ? w_now : w_last_a;
            assign w_idle      = w_now - w_last_b;
            assign w_timed_out = CW'(w_idle) > CW'(r_timeout);

            always_comb begin
                n_tvalid_p = w_pending;
                n_active_p = w_active_a;
                n_last_p   = w_last_a;
                n_relay_p  = 1'b0;
                if (w_pending) begin
                    n_relay_p = 1'b1;
                end else if (w_active_a) begin
                    n_last_p  = w_last_b;
                    n_relay_p = w_trig;
                    if (w_timed_out) begin
                        n_active_p = 1'b0;
                        n_relay_p  = 1'b0;
                    end
                end
            end

            assign n_until[g]  = n_until_p;
            assign n_tvalid[g] = n_tvalid_p;
            assign n_active[g] = n_active_p;
            assign n_last[g]   = n_last_p;
            assign n_relay[g]  = n_relay_p;
        end
    endgenerate

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relay_active_low <= 1'b0;
            r_coin_high        <= 2'b00;
            r_timeout          <= TIMEOUT_RESET;
            r_pulse            <= PULSE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RELAY_ACTIVE_LOW:   r_relay_active_low <= i_cfg_wdata[0];
                CFG_P1_COIN_HIGH:       r_coin_high[0]     <= i_cfg_wdata[0];
                CFG_P2_COIN_HIGH:       r_coin_high[1]     <= i_cfg_wdata[0];
                CFG_INACTIVITY_TIMEOUT: r_timeout          <= i_cfg_wdata;
                CFG_TEST_PULSE:         r_pulse            <= i_cfg_wdata[PULSE_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    // Valid flags of the input and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= w_accept || (r_in_vld && !w_adv);
            r_out_vld <= w_adv || (r_out_vld && i_out_stall);
        end
    end

    // Input item register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_item;
        end
    end

    // Result item register.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.p1_relay_level     <= n_relay[0] ^ r_relay_active_low;
            r_out.p2_relay_level     <= n_relay[1] ^ r_relay_active_low;
            r_out.p1_relay_energized <= n_relay[0];
            r_out.p2_relay_energized <= n_relay[1];
            r_out.p1_session_active  <= n_active[0];
            r_out.p2_session_active  <= n_active[1];
        end
    end

    // Player state commits when the item moves into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < 2; p++) begin
                r_active[p] <= 1'b0;
                r_last[p]   <= '0;
                r_until[p]  <= '0;
                r_tvalid[p] <= 1'b0;
            end
        end else if (w_adv) begin
            for (int p = 0; p < 2; p++) begin
                r_active[p] <= n_active[p];
                r_last[p]   <= n_last[p];
                r_until[p]  <= n_until[p];
                r_tvalid[p] <= n_tvalid[p];
            end
        end
    end

endmodule

// ----- hw/rtl/csrt_checker.sv -----
// Port-level checker for the coin session relay timer and its bind to the
// top level. Depends on csrt_pkg and coin_session_relay_timer_unit.

module csrt_checker
    import csrt_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input t_tick_in                   i_in_item,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input t_tick_out                  o_out_item,
    input logic                       i_cfg_we,
    input logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input logic [CFG_DATA_WIDTH-1:0]  i_cfg_wdata
);

    // A stalled result item stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("result item changed while stalled");

    // No result item is shown right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !o_out_valid)
        else $error("result valid right after reset");

    // The input side only stalls while a result item is waiting.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result waiting");

    // Both relays share one polarity, so level and on state differ alike.
    a_same_polarity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_out_item.p1_relay_level ^ o_out_item.p1_relay_energized) ==
             (o_out_item.p2_relay_level ^ o_out_item.p2_relay_energized)))
        else $error("relay polarity differs between players");

endmodule

bind coin_session_relay_timer_unit csrt_checker u_csrt_checker (.*);
